// File: src/itlc_pkg.sv
// Shared types and codes for the IP tunnelling link client.
// Used by ip_tunnel_link_client; depends on nothing else.
package itlc_pkg;

  localparam int unsigned MaxRes = 5;

  typedef struct packed {
    logic [2:0]  func;
    logic        parse_ok;
    logic [7:0]  rx_status;
    logic [7:0]  rx_channel;
    logic [7:0]  rx_seqno;
    logic [7:0]  crd_length;
    logic [15:0] crd_address;
    logic [7:0]  cemi_code;
    logic        cemi_valid;
    logic        dest_individual;
    logic [15:0] dest_address;
    logic        queue_has_frame;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [7:0]  tx_channel;
    logic [7:0]  tx_seqno;
    logic [15:0] out_dest;
    logic [3:0]  error;
    logic [1:0]  link_state;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    LINK_IDLE = 3'b001,
    LINK_CONN = 3'b010,
    LINK_WAIT = 3'b100
  } link_mode_t;

  localparam logic [1:0] LS_IDLE = 2'd0;
  localparam logic [1:0] LS_CONN = 2'd1;
  localparam logic [1:0] LS_WAIT = 2'd2;

  localparam logic [2:0] FN_TICK       = 3'd0;
  localparam logic [2:0] FN_CONN_RESP  = 3'd1;
  localparam logic [2:0] FN_TUNNEL_REQ = 3'd2;
  localparam logic [2:0] FN_TUNNEL_ACK = 3'd3;
  localparam logic [2:0] FN_STATE_RESP = 3'd4;
  localparam logic [2:0] FN_DISC_REQ   = 3'd5;
  localparam logic [2:0] FN_OTHER      = 3'd6;
  localparam logic [2:0] FN_SHUTDOWN   = 3'd7;

  localparam logic [3:0] ACT_NONE       = 4'd0;
  localparam logic [3:0] ACT_CONN_REQ   = 4'd1;
  localparam logic [3:0] ACT_TUNNEL_ACK = 4'd2;
  localparam logic [3:0] ACT_TUNNEL_REQ = 4'd3;
  localparam logic [3:0] ACT_STATE_REQ  = 4'd4;
  localparam logic [3:0] ACT_DISC_REQ   = 4'd5;
  localparam logic [3:0] ACT_DISC_RESP  = 4'd6;
  localparam logic [3:0] ACT_DATA       = 4'd7;
  localparam logic [3:0] ACT_MONITOR    = 4'd8;
  localparam logic [3:0] ACT_POP        = 4'd9;

  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_UNEXPECTED = 4'd1;
  localparam logic [3:0] ERR_PARSE      = 4'd2;
  localparam logic [3:0] ERR_CHANNEL    = 4'd3;
  localparam logic [3:0] ERR_SEQUENCE   = 4'd4;
  localparam logic [3:0] ERR_STATUS     = 4'd5;
  localparam logic [3:0] ERR_CEMI       = 4'd6;
  localparam logic [3:0] ERR_ACK        = 4'd7;
  localparam logic [3:0] ERR_DUPLICATE  = 4'd8;
  localparam logic [3:0] ERR_HEARTBEAT  = 4'd9;

  localparam logic [2:0] CFG_BUS_MONITOR     = 3'd0;
  localparam logic [2:0] CFG_VIRTUAL_MONITOR = 3'd1;
  localparam logic [2:0] CFG_HB_LIMIT        = 3'd2;
  localparam logic [2:0] CFG_HB_PERIOD       = 3'd3;
  localparam logic [2:0] CFG_RETRY_PERIOD    = 3'd4;
  localparam logic [2:0] CFG_ACK_TIMEOUT     = 3'd5;

  localparam logic [2:0] HB_LIMIT_RST     = 3'd5;
  localparam logic [7:0] HB_PERIOD_RST    = 8'd30;
  localparam logic [7:0] RETRY_PERIOD_RST = 8'd10;
  localparam logic [7:0] ACK_TIMEOUT_RST  = 8'd1;

  localparam logic [7:0] CEMI_IND    = 8'h29;
  localparam logic [7:0] CEMI_CON    = 8'h2E;
  localparam logic [7:0] CRD_LEN_TUN = 8'd3;

  function automatic out_item_t make_res(logic [3:0] act, logic [7:0] ch,
                                         logic [7:0] seq, logic [15:0] dest,
                                         logic [3:0] err);
    out_item_t r;
    r.action     = act;
    r.tx_channel = ch;
    r.tx_seqno   = seq;
    r.out_dest   = dest;
    r.error      = err;
    r.link_state = LS_IDLE;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic logic [1:0] link_code(link_mode_t m);
    logic [1:0] c;
    case (m)
      LINK_IDLE: c = LS_IDLE;
      LINK_CONN: c = LS_CONN;
      LINK_WAIT: c = LS_WAIT;
      default:   c = LS_IDLE;
    endcase
    return c;
  endfunction

endpackage

// File: src/ip_tunnel_link_client.sv
// Top level of the IP tunnelling link client: link state, timers, result buffer.
// Depends on itlc_pkg.

// An accepted item is handled in the cycle it transfers: the link state updates at
// that edge and the item's zero to five results load into a five-entry result
// buffer, which drains one result per cycle on the out_ channel while out_ready is
// high. The next item transfers in the cycle the final result of the previous one
// transfers. Items with no result (a shutdown with no channel assigned, a clean
// connect or state response) leave the buffer empty. Configuration registers are
// written through cfg_we/cfg_index/cfg_wdata; indexes beyond the list are dropped.
module ip_tunnel_link_client
  import itlc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic       bus_monitor_r, virtual_monitor_r;
  logic [2:0] hb_limit_r;
  logic [7:0] hb_period_r, retry_period_r, ack_timeout_r;

  link_mode_t  mode_r, mode_nxt;
  logic        started_r, started_nxt;
  logic [7:0]  chan_id_r, chan_id_nxt;
  logic        chan_valid_r, chan_valid_nxt;
  logic [7:0]  recv_seq_r, recv_seq_nxt;
  logic [7:0]  send_seq_r, send_seq_nxt;
  logic [2:0]  hb_pending_r, hb_pending_nxt;
  logic [15:0] own_addr_r, own_addr_nxt;
  logic [7:0]  link_timer_r, link_timer_nxt;
  logic [7:0]  ack_timer_r, ack_timer_nxt;

  out_item_t   res [MaxRes];
  logic [2:0]  res_n;
  out_item_t   slot_r [MaxRes];
  logic [2:0]  cnt_r, idx_r;

  logic in_xfer, out_xfer, drain_done, chan_ok;

  assign out_valid  = (cnt_r != 3'd0);
  assign out_data   = slot_r[idx_r];
  assign out_xfer   = out_valid && out_ready;
  assign drain_done = out_xfer && (idx_r == cnt_r - 3'd1);
  assign in_ready   = !out_valid || drain_done;
  assign in_xfer    = in_valid && in_ready;
  assign chan_ok    = chan_valid_r && (in_data.rx_channel == chan_id_r);

  always_comb begin
    mode_nxt       = mode_r;
    started_nxt    = started_r;
    chan_id_nxt    = chan_id_r;
    chan_valid_nxt = chan_valid_r;
    recv_seq_nxt   = recv_seq_r;
    send_seq_nxt   = send_seq_r;
    hb_pending_nxt = hb_pending_r;
    own_addr_nxt   = own_addr_r;
    link_timer_nxt = link_timer_r;
    ack_timer_nxt  = ack_timer_r;
    for (int i = 0; i < MaxRes; i++) begin
      res[i] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_NONE);
    end
    res_n = 3'd0;

    if (in_data.func == FN_SHUTDOWN) begin
      if (started_r) begin
        if (chan_valid_r) begin
          res[res_n] = make_res(ACT_DISC_REQ, chan_id_r, 8'd0, 16'd0, ERR_NONE);
          res_n = res_n + 3'd1;
        end
        mode_nxt       = LINK_IDLE;
        started_nxt    = 1'b0;
        chan_id_nxt    = 8'd0;
        chan_valid_nxt = 1'b0;
        recv_seq_nxt   = 8'd0;
        send_seq_nxt   = 8'd0;
        hb_pending_nxt = 3'd0;
        own_addr_nxt   = 16'd0;
        link_timer_nxt = retry_period_r;
        ack_timer_nxt  = 8'd0;
      end
    end else begin
      if (!started_r) begin
        started_nxt    = 1'b1;
        link_timer_nxt = retry_period_r;
        res[res_n] = make_res(ACT_CONN_REQ, 8'd0, 8'd0, 16'd0, ERR_NONE);
        res_n = res_n + 3'd1;
      end
      case (in_data.func)
        FN_TICK: begin
          if (mode_nxt == LINK_WAIT) begin
            if (ack_timer_nxt <= 8'd1) begin
              ack_timer_nxt = 8'd0;
              mode_nxt      = LINK_CONN;
            end else begin
              ack_timer_nxt = ack_timer_nxt - 8'd1;
            end
          end
          if (link_timer_nxt > 8'd1) begin
            link_timer_nxt = link_timer_nxt - 8'd1;
          end else if (mode_nxt != LINK_IDLE) begin
            link_timer_nxt = hb_period_r;
            if (hb_pending_r < hb_limit_r) begin
              res[res_n] = make_res(ACT_STATE_REQ, chan_id_r, 8'd0, 16'd0, ERR_NONE);
              res_n = res_n + 3'd1;
              hb_pending_nxt = hb_pending_r + 3'd1;
            end else begin
              if (chan_valid_r) begin
                res[res_n] = make_res(ACT_DISC_REQ, chan_id_r, 8'd0, 16'd0, ERR_HEARTBEAT);
              end else begin
                res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_HEARTBEAT);
              end
              res_n = res_n + 3'd1;
              mode_nxt = LINK_IDLE;
            end
          end else begin
            link_timer_nxt = retry_period_r;
            res[res_n] = make_res(ACT_CONN_REQ, 8'd0, 8'd0, 16'd0, ERR_NONE);
            res_n = res_n + 3'd1;
          end
        end
        FN_CONN_RESP: begin
          if (mode_r != LINK_IDLE) begin
            res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_UNEXPECTED);
            res_n = res_n + 3'd1;
          end else if (!in_data.parse_ok || in_data.crd_length != CRD_LEN_TUN
                       && in_data.rx_status == 8'd0) begin
            res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_PARSE);
            res_n = res_n + 3'd1;
          end else if (in_data.rx_status != 8'd0) begin
            res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_STATUS);
            res_n = res_n + 3'd1;
          end else begin
            own_addr_nxt   = in_data.crd_address;
            chan_id_nxt    = in_data.rx_channel;
            chan_valid_nxt = 1'b1;
            mode_nxt       = LINK_CONN;
            link_timer_nxt = hb_period_r;
            hb_pending_nxt = 3'd0;
          end
        end
        FN_TUNNEL_REQ: begin
          if (mode_r == LINK_IDLE) begin
            res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_UNEXPECTED);
            res_n = res_n + 3'd1;
          end else if (!in_data.parse_ok) begin
            res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_PARSE);
            res_n = res_n + 3'd1;
          end else if (!chan_ok) begin
            res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_CHANNEL);
            res_n = res_n + 3'd1;
          end else if (in_data.rx_seqno != recv_seq_r) begin
            res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_SEQUENCE);
            res_n = res_n + 3'd1;
          end else begin
            recv_seq_nxt = recv_seq_r + 8'd1;
            res[res_n] = make_res(ACT_TUNNEL_ACK, chan_id_r, in_data.rx_seqno, 16'd0,
                                  ERR_NONE);
            res_n = res_n + 3'd1;
            if (in_data.cemi_code != CEMI_CON) begin
              if (in_data.cemi_code != CEMI_IND || !in_data.cemi_valid) begin
                res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_CEMI);
                res_n = res_n + 3'd1;
              end else if (!bus_monitor_r) begin
                if (virtual_monitor_r) begin
                  res[res_n] = make_res(ACT_MONITOR, 8'd0, 8'd0, in_data.dest_address,
                                        ERR_NONE);
                  res_n = res_n + 3'd1;
                end
                res[res_n] = make_res(ACT_DATA, 8'd0, 8'd0,
                                      (in_data.dest_individual &&
                                       in_data.dest_address == own_addr_r) ?
                                      16'd0 : in_data.dest_address, ERR_NONE);
                res_n = res_n + 3'd1;
              end else begin
                res[res_n] = make_res(ACT_MONITOR, 8'd0, 8'd0, in_data.dest_address,
                                      ERR_NONE);
                res_n = res_n + 3'd1;
              end
            end
          end
        end
        FN_TUNNEL_ACK: begin
          if (mode_r == LINK_IDLE) begin
            res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_UNEXPECTED);
          end else if (!in_data.parse_ok) begin
            res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_PARSE);
          end else if (!chan_ok) begin
            res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_CHANNEL);
          end else if (in_data.rx_seqno != send_seq_r) begin
            res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_SEQUENCE);
          end else if (in_data.rx_status != 8'd0) begin
            res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_STATUS);
          end else if (mode_r == LINK_WAIT) begin
            send_seq_nxt  = send_seq_r + 8'd1;
            mode_nxt      = LINK_CONN;
            ack_timer_nxt = 8'd0;
            res[res_n] = make_res(ACT_POP, 8'd0, 8'd0, 16'd0, ERR_NONE);
          end else begin
            res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_ACK);
          end
          res_n = res_n + 3'd1;
        end
        FN_STATE_RESP: begin
          if (!in_data.parse_ok) begin
            res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_PARSE);
            res_n = res_n + 3'd1;
          end else if (!chan_ok) begin
            res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_CHANNEL);
            res_n = res_n + 3'd1;
          end else if (in_data.rx_status != 8'd0) begin
            res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_STATUS);
            res_n = res_n + 3'd1;
          end else if (hb_pending_r != 3'd0) begin
            hb_pending_nxt = hb_pending_r - 3'd1;
          end else begin
            res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_DUPLICATE);
            res_n = res_n + 3'd1;
          end
        end
        FN_DISC_REQ: begin
          if (mode_r == LINK_IDLE) begin
            res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_UNEXPECTED);
          end else if (!in_data.parse_ok) begin
            res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_PARSE);
          end else if (!chan_ok) begin
            res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_CHANNEL);
          end else begin
            res[res_n] = make_res(ACT_DISC_RESP, chan_id_r, 8'd0, 16'd0, ERR_NONE);
            mode_nxt = LINK_IDLE;
          end
          res_n = res_n + 3'd1;
        end
        default: begin
          res[res_n] = make_res(ACT_NONE, 8'd0, 8'd0, 16'd0, ERR_UNEXPECTED);
          res_n = res_n + 3'd1;
        end
      endcase
      if (in_data.queue_has_frame && mode_nxt == LINK_CONN) begin
        res[res_n] = make_res(ACT_TUNNEL_REQ, chan_id_nxt, send_seq_nxt, 16'd0, ERR_NONE);
        res_n = res_n + 3'd1;
        mode_nxt      = LINK_WAIT;
        ack_timer_nxt = ack_timeout_r;
      end
    end

    for (int i = 0; i < MaxRes; i++) begin
      res[i].link_state = link_code(mode_nxt);
      res[i].last       = (3'(i) == res_n - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_monitor_r     <= 1'b0;
      virtual_monitor_r <= 1'b0;
      hb_limit_r        <= HB_LIMIT_RST;
      hb_period_r       <= HB_PERIOD_RST;
      retry_period_r    <= RETRY_PERIOD_RST;
      ack_timeout_r     <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BUS_MONITOR:     bus_monitor_r     <= cfg_wdata[0];
        CFG_VIRTUAL_MONITOR: virtual_monitor_r <= cfg_wdata[0];
        CFG_HB_LIMIT:        hb_limit_r        <= cfg_wdata[2:0];
        CFG_HB_PERIOD:       hb_period_r       <= cfg_wdata;
        CFG_RETRY_PERIOD:    retry_period_r    <= cfg_wdata;
        CFG_ACK_TIMEOUT:     ack_timeout_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= LINK_IDLE;
      started_r    <= 1'b0;
      chan_id_r    <= 8'd0;
      chan_valid_r <= 1'b0;
      recv_seq_r   <= 8'd0;
      send_seq_r   <= 8'd0;
      hb_pending_r <= 3'd0;
      own_addr_r   <= 16'd0;
      link_timer_r <= RETRY_PERIOD_RST;
      ack_timer_r  <= 8'd0;
    end else if (in_xfer) begin
      mode_r       <= mode_nxt;
      started_r    <= started_nxt;
      chan_id_r    <= chan_id_nxt;
      chan_valid_r <= chan_valid_nxt;
      recv_seq_r   <= recv_seq_nxt;
      send_seq_r   <= send_seq_nxt;
      hb_pending_r <= hb_pending_nxt;
      own_addr_r   <= own_addr_nxt;
      link_timer_r <= link_timer_nxt;
      ack_timer_r  <= ack_timer_nxt;
    end
  end

  // Result buffer: load on input transfer, advance on output transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      idx_r <= 3'd0;
    end else if (in_xfer) begin
      cnt_r <= res_n;
      idx_r <= 3'd0;
    end else if (drain_done) begin
      cnt_r <= 3'd0;
      idx_r <= 3'd0;
    end else if (out_xfer) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < MaxRes; i++) begin
        slot_r[i] <= res[i];
      end
    end
  end

endmodule
